// File: hdl/bfba_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit bin assigner package
// Shared types and codes for the best-fit bin assigner and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package bfba_pkg;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_PLACE = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Result status codes carried on the output tuser bits.
  localparam logic [1:0] STATUS_PLACED  = 2'd0;
  localparam logic [1:0] STATUS_OVERCAP = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_CLEARED = 2'd3;

  // Bin capacity after reset.
  localparam int CAP_RESET = 100;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// File: hdl/bfba_residual_ram.sv
// ----------------------------------------------------------------------------
// Residual space memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_residual_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/best_fit_bin_assigner.sv
// ----------------------------------------------------------------------------
// Best-fit bin assigner
// Online best-fit bin packing over a memory of per-bin residual space.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser selects place or clear, and
//   s_tdata carries the item weight. Each request gives exactly one result
//   beat on the m_ stream: bin index, new-bin flag, space left and bins in
//   use in m_tdata, and the status code in m_tuser.
//   The bin capacity is written on the cfg_ channel while the block is idle
//   and no request beat is on offer.
//   A place request reads the open bins one per cycle from the residual
//   memory and a single subtract-and-compare unit keeps the best fit.
//   A place request with bins open then passes the drain and finish
//   states before its result beat is valid. A clear, an overweight item
//   or a place with no bins open goes from idle straight to the finish
//   state, where its result is registered.
//   s_tready is high only while the sequencer is idle; a finished result
//   sits in the output register, so the next request is taken while it
//   waits. When the receiver stalls with a result still held, the next
//   request waits in its final cycle until the output register is free.
//   Reset empties all bins and sets the capacity to 100; the residual
//   memory needs no clearing pass since only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_bin_assigner #(
  parameter int MAX_BINS    = 64,
  parameter int WEIGHT_BITS = 16,
  localparam int IDX_W      = $clog2(MAX_BINS),
  localparam int CNT_W      = $clog2(MAX_BINS + 1),
  localparam int S_DATA_W   = ((WEIGHT_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = IDX_W + 1 + WEIGHT_BITS + CNT_W,
  localparam int M_DATA_W   = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Capacity write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [WEIGHT_BITS-1:0] cfg_data,
  // Request stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [S_DATA_W-1:0]    s_tdata,   // item_weight
  input  wire logic [0:0]             s_tuser,   // req_type
  // Result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [M_DATA_W-1:0]         m_tdata,   // bin_index, opened_new, space_left,
                                                 // bins_in_use
  output logic [1:0]                  m_tuser    // status
);

  bfba_pkg::state_t state;

  logic [WEIGHT_BITS-1:0] cap;
  logic [CNT_W-1:0]       open_bins;
  logic                   req_clear;
  logic                   over;
  logic [WEIGHT_BITS-1:0] weight;
  logic [CNT_W-1:0]       scan_idx;
  logic                   cmp_valid;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   found;
  logic [IDX_W-1:0]       best_idx;
  logic [WEIGHT_BITS-1:0] best_left;

  logic [IDX_W-1:0]       out_bin_index;
  logic                   out_opened_new;
  logic [WEIGHT_BITS-1:0] out_space_left;
  logic [CNT_W-1:0]       out_bins_in_use;
  logic [1:0]             out_status;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_wr_addr;
  logic [WEIGHT_BITS-1:0] ram_wr_data;
  logic                   ram_rd_en;
  logic [WEIGHT_BITS-1:0] ram_rd_data;

  logic                   in_beat;
  logic                   out_free;
  logic                   finish_go;
  logic                   has_room;
  logic                   fits;
  logic [WEIGHT_BITS-1:0] left;
  logic                   take;
  logic [WEIGHT_BITS-1:0] new_left;
  logic [WEIGHT_BITS-1:0] in_weight;

  // The capacity only changes while no request is in progress or on offer.
  assign cfg_ready = (state == bfba_pkg::ST_IDLE) && !s_tvalid;
  assign s_tready  = (state == bfba_pkg::ST_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign in_weight = s_tdata[WEIGHT_BITS-1:0];
  assign out_free  = !m_tvalid || m_tready;
  assign finish_go = (state == bfba_pkg::ST_FINISH) && out_free;
  assign has_room  = (open_bins < CNT_W'(MAX_BINS));
  assign new_left  = cap - weight;

  // Shared compare unit: residual of the bin read last cycle against the best so far.
  assign fits = (ram_rd_data >= weight);
  assign left = ram_rd_data - weight;
  assign take = cmp_valid && fits && (!found || (left < best_left));

  // Residual memory accesses.
  assign ram_rd_en   = (state == bfba_pkg::ST_SCAN);
  assign ram_we      = finish_go && !req_clear && !over && (found || has_room);
  assign ram_wr_addr = found ? best_idx : open_bins[IDX_W-1:0];
  assign ram_wr_data = found ? best_left : new_left;

  bfba_residual_ram #(
    .DEPTH  (MAX_BINS),
    .WIDTH  (WEIGHT_BITS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= WEIGHT_BITS'(bfba_pkg::CAP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      cap <= cfg_data;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_clear <= (s_tuser[0] == bfba_pkg::REQ_CLEAR);
      over      <= (in_weight > cap);
      weight    <= in_weight;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfba_pkg::ST_IDLE;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        bfba_pkg::ST_IDLE: begin
          scan_idx  <= '0;
          cmp_valid <= 1'b0;
          if (in_beat) begin
            if (s_tuser[0] == bfba_pkg::REQ_PLACE && in_weight <= cap &&
                open_bins != '0) begin
              state <= bfba_pkg::ST_SCAN;
            end else begin
              state <= bfba_pkg::ST_FINISH;
            end
          end
        end
        bfba_pkg::ST_SCAN: begin
          cmp_valid <= 1'b1;
          cmp_idx   <= scan_idx[IDX_W-1:0];
          scan_idx  <= scan_idx + 1'b1;
          if (scan_idx == open_bins - 1'b1) begin
            state <= bfba_pkg::ST_DRAIN;
          end
        end
        bfba_pkg::ST_DRAIN: begin
          cmp_valid <= 1'b0;
          state     <= bfba_pkg::ST_FINISH;
        end
        bfba_pkg::ST_FINISH: begin
          if (out_free) begin
            state <= bfba_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= bfba_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Best fit tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (in_beat) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx  <= cmp_idx;
      best_left <= left;
    end
  end

  // Open bin count.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_bins <= '0;
    end else if (finish_go) begin
      if (req_clear) begin
        open_bins <= '0;
      end else if (!over && !found && has_room) begin
        open_bins <= open_bins + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_bin_index   <= '0;
      out_opened_new  <= 1'b0;
      out_space_left  <= '0;
      out_bins_in_use <= open_bins;
      if (req_clear) begin
        out_bins_in_use <= '0;
        out_status      <= bfba_pkg::STATUS_CLEARED;
      end else if (over) begin
        out_status <= bfba_pkg::STATUS_OVERCAP;
      end else if (found) begin
        out_bin_index  <= best_idx;
        out_space_left <= best_left;
        out_status     <= bfba_pkg::STATUS_PLACED;
      end else if (!has_room) begin
        out_status <= bfba_pkg::STATUS_FULL;
      end else begin
        out_bin_index   <= open_bins[IDX_W-1:0];
        out_opened_new  <= 1'b1;
        out_space_left  <= new_left;
        out_bins_in_use <= open_bins + 1'b1;
        out_status      <= bfba_pkg::STATUS_PLACED;
      end
    end
  end

  // Result packing, first field in the lowest bits.
  always_comb begin
    m_tdata = '0;
    m_tdata[0 +: IDX_W]                       = out_bin_index;
    m_tdata[IDX_W]                            = out_opened_new;
    m_tdata[IDX_W + 1 +: WEIGHT_BITS]         = out_space_left;
    m_tdata[IDX_W + 1 + WEIGHT_BITS +: CNT_W] = out_bins_in_use;
  end

  assign m_tuser = out_status;

  // Checks on the sequencer and the bin bookkeeping.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    open_bins <= CNT_W'(MAX_BINS))
    else $error("open bin count above the number of bins");

  a_best_open: assert property (@(posedge clk) disable iff (rst)
    (state == bfba_pkg::ST_FINISH && found) |-> (CNT_W'(best_idx) < open_bins))
    else $error("best bin is not an open bin");

  a_write_finish: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == bfba_pkg::ST_FINISH))
    else $error("residual write outside the final cycle");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == bfba_pkg::ST_FINISH))
    else $error("result raised without a finished request");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == bfba_pkg::ST_SCAN) |-> (scan_idx < open_bins))
    else $error("scan address beyond the open bins");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Best-fit bin assigner testbench
// Drives place and clear requests into the block and checks every result
// beat. A table of directed requests comes first, followed by random runs
// under several bin capacities and idling patterns. A local best-fit model
// of the bins predicts each result.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int NUM_BINS     = 64;
  localparam int DRAIN_CYCLES = NUM_BINS + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_SEGMENTS = 6;
  localparam int SEG_ITEMS    = 78;

  // One result, field by field.
  typedef struct packed {
    logic [5:0]  bin_index;
    logic        opened_new;
    logic [15:0] space_left;
    logic [6:0]  bins_in_use;
    logic [1:0]  status;
  } placement_t;

  // One row of directed stimulus; a typed result is used only when known.
  typedef struct packed {
    logic        req;
    logic [15:0] weight;
    logic        typed;
    placement_t  res;
  } bin_request_t;

  localparam placement_t NO_RESULT = '0;
  localparam int NUM_DIRECTED = 18;

  localparam bin_request_t DIRECTED_STEPS [0:NUM_DIRECTED-1] = '{
    // Over capacity with no bin open, then the largest weight.
    '{bfba_pkg::REQ_PLACE, 16'd101,  1'b1,
      '{6'd0, 1'b0, 16'd0, 7'd0, bfba_pkg::STATUS_OVERCAP}},
    '{bfba_pkg::REQ_PLACE, 16'hFFFF, 1'b1,
      '{6'd0, 1'b0, 16'd0, 7'd0, bfba_pkg::STATUS_OVERCAP}},
    // Zero weight with nothing open opens a bin at full capacity.
    '{bfba_pkg::REQ_PLACE, 16'd0,    1'b1,
      '{6'd0, 1'b1, 16'd100, 7'd1, bfba_pkg::STATUS_PLACED}},
    '{bfba_pkg::REQ_PLACE, 16'd100,  1'b0, NO_RESULT},
    '{bfba_pkg::REQ_PLACE, 16'd0,    1'b0, NO_RESULT},
    '{bfba_pkg::REQ_PLACE, 16'd60,   1'b0, NO_RESULT},
    '{bfba_pkg::REQ_PLACE, 16'd60,   1'b0, NO_RESULT},
    // Tie between two bins with equal space: the lower index wins.
    '{bfba_pkg::REQ_PLACE, 16'd10,   1'b0, NO_RESULT},
    '{bfba_pkg::REQ_PLACE, 16'd35,   1'b0, NO_RESULT},
    '{bfba_pkg::REQ_PLACE, 16'd30,   1'b0, NO_RESULT},
    '{bfba_pkg::REQ_PLACE, 16'd101,  1'b1,
      '{6'd0, 1'b0, 16'd0, 7'd3, bfba_pkg::STATUS_OVERCAP}},
    // Clear with bins open, then clear when already empty.
    '{bfba_pkg::REQ_CLEAR, 16'd0,    1'b1,
      '{6'd0, 1'b0, 16'd0, 7'd0, bfba_pkg::STATUS_CLEARED}},
    '{bfba_pkg::REQ_CLEAR, 16'd0,    1'b1,
      '{6'd0, 1'b0, 16'd0, 7'd0, bfba_pkg::STATUS_CLEARED}},
    '{bfba_pkg::REQ_PLACE, 16'd100,  1'b1,
      '{6'd0, 1'b1, 16'd0, 7'd1, bfba_pkg::STATUS_PLACED}},
    '{bfba_pkg::REQ_PLACE, 16'd1,    1'b0, NO_RESULT},
    // A clear ignores whatever weight travels with it.
    '{bfba_pkg::REQ_CLEAR, 16'hFFFF, 1'b1,
      '{6'd0, 1'b0, 16'd0, 7'd0, bfba_pkg::STATUS_CLEARED}},
    '{bfba_pkg::REQ_PLACE, 16'h5555, 1'b1,
      '{6'd0, 1'b0, 16'd0, 7'd0, bfba_pkg::STATUS_OVERCAP}},
    '{bfba_pkg::REQ_PLACE, 16'hAAAA, 1'b1,
      '{6'd0, 1'b0, 16'd0, 7'd0, bfba_pkg::STATUS_OVERCAP}}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // item_weight
  logic [0:0]  s_tuser   = '0;   // req_type
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;          // bin_index, opened_new, space_left, bins_in_use
  logic [1:0]  m_tuser;          // status

  // Model of the bins, kept in step with accepted request beats.
  logic [15:0] bin_space [0:NUM_BINS-1];
  logic [6:0]  open_count = '0;
  logic [15:0] capacity   = 16'(bfba_pkg::CAP_RESET);

  placement_t  expected_placements [$];
  int          fail_count    = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  best_fit_bin_assigner dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run guard: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate the current phase sets.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Best-fit placement of one request, updating the model of the bins.
  task automatic place_best_fit(input logic req, input logic [15:0] w,
                                output placement_t r);
    logic        found;
    logic [5:0]  best;
    logic [15:0] best_left;
    found     = 1'b0;
    best      = '0;
    best_left = '0;
    r         = '0;
    if (req == bfba_pkg::REQ_CLEAR) begin
      open_count = '0;
      r.status   = bfba_pkg::STATUS_CLEARED;
    end else if (w > capacity) begin
      r.bins_in_use = open_count;
      r.status      = bfba_pkg::STATUS_OVERCAP;
    end else begin
      for (int j = 0; j < open_count; j++) begin
        if (bin_space[j] >= w) begin
          if (!found || (bin_space[j] - w) < best_left) begin
            found     = 1'b1;
            best      = 6'(j);
            best_left = bin_space[j] - w;
          end
        end
      end
      if (found) begin
        bin_space[best] = best_left;
        r.bin_index     = best;
        r.space_left    = best_left;
        r.bins_in_use   = open_count;
        r.status        = bfba_pkg::STATUS_PLACED;
      end else if (open_count >= 7'(NUM_BINS)) begin
        r.bins_in_use = open_count;
        r.status      = bfba_pkg::STATUS_FULL;
      end else begin
        bin_space[open_count[5:0]] = capacity - w;
        r.bin_index   = open_count[5:0];
        r.opened_new  = 1'b1;
        r.space_left  = capacity - w;
        open_count    = open_count + 7'd1;
        r.bins_in_use = open_count;
        r.status      = bfba_pkg::STATUS_PLACED;
      end
    end
  endtask

  // Random weight, spread over zero, exact fits, overweight and the full range.
  function automatic logic [15:0] pick_weight(input logic [15:0] cap);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5)
      return 16'd0;
    else if (pick < 10)
      return cap;
    else if (pick < 15)
      return (cap == 16'hFFFF) ? cap : 16'($urandom_range(int'(cap) + 1, 65535));
    else if (pick < 25)
      return 16'($urandom());
    else if (pick < 45)
      return 16'($urandom_range(0, cap / 4));
    else
      return 16'($urandom_range(cap / 2, cap));
  endfunction

  // Present one request beat, with a random gap first, and predict its result.
  task automatic send_request(input logic req, input logic [15:0] w,
                              input logic typed, input placement_t typed_res);
    placement_t predicted;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    place_best_fit(req, w, predicted);
    if (typed) predicted = typed_res;
    expected_placements = {expected_placements, predicted};
  endtask

  // Hold off the sender until every result is back, then maybe write the
  // capacity register while the block is idle.
  task automatic drain_and_configure(input logic write_cap, input logic [15:0] cap);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    if (write_cap) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= cap;
      do @(posedge clk); while (!cfg_ready);
      capacity = cap;
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Every result beat is compared with the oldest outstanding prediction.
  always @(posedge clk) begin : result_monitor
    placement_t got;
    placement_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.bin_index   = m_tdata[5:0];
      got.opened_new  = m_tdata[6];
      got.space_left  = m_tdata[22:7];
      got.bins_in_use = m_tdata[29:23];
      got.status      = m_tuser;
      if (expected_placements.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_count++;
      end else begin
        want = expected_placements.pop_front();
        check_field("bin_index", want.bin_index, got.bin_index);
        check_field("opened_new", want.opened_new, got.opened_new);
        check_field("space_left", want.space_left, got.space_left);
        check_field("bins_in_use", want.bins_in_use, got.bins_in_use);
        check_field("status", want.status, got.status);
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    logic [15:0] seg_cap;
    for (int i = 0; i < NUM_BINS; i++) bin_space[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: sender idles lightly, receiver heavily.
    send_idle_pct = 15;
    recv_idle_pct = 45;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(DIRECTED_STEPS[i].req, DIRECTED_STEPS[i].weight,
                   DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].res);
    end

    // Random phases under changing capacity; bins carry over unless cleared.
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      case (seg)
        0:       seg_cap = capacity;
        1:       seg_cap = 16'hFFFF;
        2:       seg_cap = 16'd1;
        5:       seg_cap = 16'(bfba_pkg::CAP_RESET);
        default: seg_cap = 16'($urandom_range(2, 65534));
      endcase
      drain_and_configure(seg != 0, seg_cap);
      case (seg / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (seg == 0) begin
        // Items above half capacity never share a bin, so this fills all bins.
        send_request(bfba_pkg::REQ_CLEAR, 16'($urandom()), 1'b0, NO_RESULT);
        repeat (NUM_BINS + 2)
          send_request(bfba_pkg::REQ_PLACE,
                       16'($urandom_range(capacity / 2 + 1, capacity)),
                       1'b0, NO_RESULT);
      end else if ($urandom_range(1) == 1) begin
        send_request(bfba_pkg::REQ_CLEAR, 16'($urandom()), 1'b0, NO_RESULT);
      end
      repeat (SEG_ITEMS) begin
        if ($urandom_range(99) == 0)
          send_request(bfba_pkg::REQ_CLEAR, 16'($urandom()), 1'b0, NO_RESULT);
        else
          send_request(bfba_pkg::REQ_PLACE, pick_weight(capacity), 1'b0, NO_RESULT);
      end
    end

    // Wait for the last results, then a little longer for stray beats.
    drain_and_configure(1'b0, capacity);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_placements.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
